[rtl/core/sarb_pkg.sv]
// Shared types and codes for the segmented audio ring buffer.
package sarb_pkg;

  // Request operation codes
  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_SEGMENT_BYTES = 1'b0,
    CFG_SEGMENT_COUNT = 1'b1
  } cfg_idx_t;

  localparam int CFG_DATA_W   = 9;
  localparam int SEG_BYTES_W  = 9;
  localparam int SEG_COUNT_W  = 7;
  localparam int ADVANCE_W    = 7;
  localparam int SEG_IDX_OUT_W = 6;
  localparam int FILL_OUT_W   = 8;

  // Input request: one byte write or one play advance
  typedef struct packed {
    op_t                  op;
    logic [7:0]           data_byte;
    logic                 last_byte;
    logic [ADVANCE_W-1:0] advance;
  } in_item_t;

  // Result for one request
  typedef struct packed {
    logic                     accepted;
    logic                     full_res;
    logic                     underrun;
    logic                     segment_done;
    logic                     write_complete;
    logic [SEG_IDX_OUT_W-1:0] play_segment;
    logic [SEG_IDX_OUT_W-1:0] write_segment;
    logic [FILL_OUT_W-1:0]    fill_count;
  } out_item_t;

  // Configuration write request
  typedef struct packed {
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_item_t;

endpackage

[rtl/core/sarb_if.sv]
// Valid/ready channel interfaces for the ring buffer's request, result and config ports.
interface sarb_in_if;
  import sarb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sarb_out_if;
  import sarb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sarb_cfg_if;
  import sarb_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/segmented_audio_ring_buffer.sv]
// Segmented byte ring buffer with play advance and underrun recovery.
//
//   port     dir  payload                                   request taken when
//   in_req   in   op, data_byte, last_byte, advance         valid & ready
//   out_rsp  out  flags, play/write segment, fill count     valid & ready
//   cfg_wr   in   register index, write data                valid & ready (ready always 1)
//
// A write request sends the byte to the store and registers the result.
// An advance computes (play + advance) mod segment_count, one quotient bit per cycle,
// in the shared remainder unit. A segment wrap past a reduced count uses it too.
// Reset is synchronous; the byte store is not cleared (no clearing pass, it is never read).
// Requests are taken in ST_IDLE while the result register is empty or drains the same cycle.
module segmented_audio_ring_buffer #(
  parameter int MAX_SEGMENTS      = 64,
  parameter int MAX_SEGMENT_BYTES = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  sarb_in_if.sink      in_req,
  sarb_out_if.source   out_rsp,
  sarb_cfg_if.sink     cfg_wr
);
  import sarb_pkg::*;

  localparam int DEPTH   = MAX_SEGMENTS * MAX_SEGMENT_BYTES;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W   = $clog2(MAX_SEGMENTS);
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int SEGB_W  = $clog2(MAX_SEGMENT_BYTES + 1);
  localparam int FILL_W  = (MAX_SEGMENT_BYTES > 1) ? $clog2(MAX_SEGMENT_BYTES) : 1;
  localparam int DIV_W   = $clog2(MAX_SEGMENTS + (1 << ADVANCE_W));
  localparam int STEP_W  = $clog2(DIV_W);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_MOD  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [SEG_BYTES_W-1:0] seg_bytes_r;
  logic [SEG_COUNT_W-1:0] seg_count_r;

  logic [IDX_W-1:0]  play_r, play_nxt;
  logic [IDX_W-1:0]  write_r, write_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  // Remainder unit
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              mod_adv_r, mod_adv_nxt;
  logic              mod_last_r, mod_last_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      out_load;

  logic [7:0] store_mem [DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;

  logic [SEGB_W-1:0] seg_eff;
  logic [CNT_W-1:0]  cnt_eff;
  logic              in_ready, in_fire, cfg_fire;
  logic [FILL_W:0]   fill_inc;
  logic              seg_full;
  logic [IDX_W:0]    wr_inc;
  logic [CNT_W:0]    trial;
  logic              trial_fits;
  logic [CNT_W-1:0]  rem_step;
  logic [IDX_W-1:0]  mod_res;
  logic [IDX_W:0]    play_inc;
  logic              f_acc, f_full, f_under, f_done, f_wcomp;

  // Effective configuration after clamping
  always_comb begin
    if (seg_bytes_r == '0) begin
      seg_eff = SEGB_W'(1);
    end else if (32'(seg_bytes_r) > 32'(MAX_SEGMENT_BYTES)) begin
      seg_eff = SEGB_W'(MAX_SEGMENT_BYTES);
    end else begin
      seg_eff = SEGB_W'(seg_bytes_r);
    end
    if (seg_count_r < SEG_COUNT_W'(2)) begin
      cnt_eff = CNT_W'(2);
    end else if (32'(seg_count_r) > 32'(MAX_SEGMENTS)) begin
      cnt_eff = CNT_W'(MAX_SEGMENTS);
    end else begin
      cnt_eff = CNT_W'(seg_count_r);
    end
  end

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_rsp.ready);
  assign in_fire  = in_req.valid && in_ready;
  assign cfg_fire = cfg_wr.valid;

  // Write-side arithmetic
  assign fill_inc = {1'b0, fill_r} + (FILL_W + 1)'(1);
  assign seg_full = 32'(fill_inc) >= 32'(seg_eff);
  assign wr_inc   = {1'b0, write_r} + (IDX_W + 1)'(1);
  assign wr_addr  = ADDR_W'(ADDR_W'(write_r) * ADDR_W'(seg_eff)) + ADDR_W'(fill_r);

  // One restoring remainder step per cycle, dividend MSB first
  assign trial      = {rem_r, div_r[DIV_W-1]};
  assign trial_fits = trial >= {1'b0, cnt_eff};
  assign rem_step   = trial_fits ? CNT_W'(trial - {1'b0, cnt_eff}) : CNT_W'(trial);
  assign mod_res    = IDX_W'(rem_step);
  assign play_inc   = {1'b0, mod_res} + (IDX_W + 1)'(1);

  // Sequencer and state update
  always_comb begin
    state_nxt    = state_r;
    play_nxt     = play_r;
    write_nxt    = write_r;
    fill_nxt     = fill_r;
    div_nxt      = div_r;
    rem_nxt      = rem_r;
    step_nxt     = step_r;
    mod_adv_nxt  = mod_adv_r;
    mod_last_nxt = mod_last_r;
    mem_we       = 1'b0;
    out_load     = 1'b0;
    f_acc        = 1'b0;
    f_full       = 1'b0;
    f_under      = 1'b0;
    f_done       = 1'b0;
    f_wcomp      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req.payload.op == OP_WRITE) begin
            if (write_r == play_r) begin
              // Ring full: refuse, state unchanged
              f_full   = 1'b1;
              out_load = 1'b1;
            end else begin
              mem_we  = 1'b1;
              f_acc   = 1'b1;
              f_wcomp = in_req.payload.last_byte;
              if (seg_full) begin
                fill_nxt = '0;
                f_done   = 1'b1;
                if (32'(wr_inc) < 32'(cnt_eff)) begin
                  write_nxt = IDX_W'(wr_inc);
                  out_load  = 1'b1;
                end else if (32'(wr_inc) == 32'(cnt_eff)) begin
                  write_nxt = '0;
                  out_load  = 1'b1;
                end else begin
                  // Count shrunk below the write index: take the long wrap
                  state_nxt    = ST_MOD;
                  div_nxt      = DIV_W'(wr_inc);
                  rem_nxt      = '0;
                  step_nxt     = STEP_W'(DIV_W - 1);
                  mod_adv_nxt  = 1'b0;
                  mod_last_nxt = in_req.payload.last_byte;
                end
              end else begin
                fill_nxt = fill_inc[FILL_W-1:0];
                out_load = 1'b1;
              end
            end
          end else begin
            state_nxt    = ST_MOD;
            div_nxt      = DIV_W'(play_r) + DIV_W'(in_req.payload.advance);
            rem_nxt      = '0;
            step_nxt     = STEP_W'(DIV_W - 1);
            mod_adv_nxt  = 1'b1;
            mod_last_nxt = 1'b0;
          end
        end
      end
      ST_MOD: begin
        rem_nxt  = rem_step;
        div_nxt  = div_r << 1;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_IDLE;
          out_load  = 1'b1;
          f_acc     = 1'b1;
          if (mod_adv_r) begin
            play_nxt = mod_res;
            if (mod_res == write_r) begin
              // Underrun: restart writing just past play
              f_under   = 1'b1;
              fill_nxt  = '0;
              write_nxt = (32'(play_inc) == 32'(cnt_eff)) ? '0 : IDX_W'(play_inc);
            end
          end else begin
            write_nxt = mod_res;
            f_done    = 1'b1;
            f_wcomp   = mod_last_r;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register
  always_comb begin
    out_data_nxt.accepted       = f_acc;
    out_data_nxt.full_res       = f_full;
    out_data_nxt.underrun       = f_under;
    out_data_nxt.segment_done   = f_done;
    out_data_nxt.write_complete = f_wcomp;
    out_data_nxt.play_segment   = SEG_IDX_OUT_W'(play_nxt);
    out_data_nxt.write_segment  = SEG_IDX_OUT_W'(write_nxt);
    out_data_nxt.fill_count     = FILL_OUT_W'(fill_nxt);
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_rsp.ready;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      play_r      <= '0;
      write_r     <= IDX_W'(1);
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      seg_bytes_r <= SEG_BYTES_W'(256);
      seg_count_r <= SEG_COUNT_W'(64);
    end else begin
      state_r     <= state_nxt;
      play_r      <= play_nxt;
      write_r     <= write_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        unique case (cfg_wr.payload.index)
          CFG_SEGMENT_BYTES: seg_bytes_r <= cfg_wr.payload.data;
          CFG_SEGMENT_COUNT: seg_count_r <= cfg_wr.payload.data[SEG_COUNT_W-1:0];
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    mod_adv_r  <= mod_adv_nxt;
    mod_last_r <= mod_last_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Byte store, write only
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[wr_addr] <= in_req.payload.data_byte;
    end
  end

  assign in_req.ready    = in_ready;
  assign out_rsp.valid   = out_valid_r;
  assign out_rsp.payload = out_data_r;
  assign cfg_wr.ready    = 1'b1;

endmodule
